FILE: src/qte_pkg.sv
package qte_pkg;

	// Output angle format and CORDIC depth
	localparam int ANGLE_WIDTH  = 16;
	localparam int CORDIC_STEPS = 16;

	// Internal widths
	localparam int QW  = 16;                // quaternion component
	localparam int PW  = 2 * QW;            // component product
	localparam int EW  = 34;                // direction cosine element
	localparam int XW  = 36;                // CORDIC x/y datapath
	localparam int ZW  = 37;                // CORDIC angle, 32 fraction bits
	localparam int TW  = 8;                 // lock threshold
	localparam int ONE_SHIFT = 28;          // 2^28 means one
	localparam int SW  = ONE_SHIFT + 2;     // clamped arcsine operand, signed, holds plus one
	localparam int VW  = 2 * ONE_SHIFT + 1; // radicand, up to 2^56
	localparam int ISQRT_STAGES = ONE_SHIFT + 1; // one root bit per stage
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int OUT_SH = 35 - ANGLE_WIDTH;
	localparam int FRONT_DLY = 3 + ISQRT_STAGES + CORDIC_LAT;

	localparam longint ONE_VAL     = 64'sd1 <<< ONE_SHIFT;
	localparam longint PI_Q32      = 64'sd13493037705;
	localparam longint HALF_PI_Q32 = 64'sd6746518852;
	localparam longint HALF_OUT    = (HALF_PI_Q32 + (64'sd1 <<< (OUT_SH - 1))) >>> OUT_SH;

	typedef enum logic [1:0] {
		LOCK_NONE = 2'd0,
		LOCK_POS  = 2'd1,
		LOCK_NEG  = 2'd2
	} lock_t;

	typedef struct packed {
		logic signed [EW-1:0] e00;
		logic signed [EW-1:0] e02;
		logic signed [EW-1:0] e10;
		logic signed [EW-1:0] e12;
		logic signed [EW-1:0] e21;
		logic signed [EW-1:0] e22;
	} elem_t;

	typedef struct packed {
		logic signed [ANGLE_WIDTH-1:0] pitch;
		lock_t                         status;
		logic signed [EW-1:0]          yaw_y;
		logic signed [EW-1:0]          yaw_x;
		logic signed [EW-1:0]          roll_y;
		logic signed [EW-1:0]          roll_x;
	} qitem_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// atan(2^-i) with 32 fraction bits, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = ZW'(64'sd3373259426);
			1:  r = ZW'(64'sd1991351318);
			2:  r = ZW'(64'sd1052175346);
			3:  r = ZW'(64'sd534100635);
			4:  r = ZW'(64'sd268086748);
			5:  r = ZW'(64'sd134174063);
			6:  r = ZW'(64'sd67103403);
			7:  r = ZW'(64'sd33553749);
			8:  r = ZW'(64'sd16777131);
			9:  r = ZW'(64'sd8388597);
			10: r = ZW'(64'sd4194303);
			default: r = ZW'(64'sd1 <<< (32 - i));
		endcase
		return r;
	endfunction

endpackage

FILE: src/qte_cordic.sv
module qte_cordic (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic signed [qte_pkg::XW-1:0]        in_y,
	input  logic signed [qte_pkg::XW-1:0]        in_x,
	output logic                                 out_valid,
	output logic signed [qte_pkg::ANGLE_WIDTH-1:0] out_angle
);

	localparam int N  = qte_pkg::CORDIC_STEPS;
	localparam int XW = qte_pkg::XW;
	localparam int ZW = qte_pkg::ZW;
	localparam int AW = qte_pkg::ANGLE_WIDTH;
	localparam logic signed [ZW-1:0] PI_Z = ZW'(qte_pkg::PI_Q32);
	localparam logic signed [ZW-1:0] RND  = ZW'(64'sd1 <<< (qte_pkg::OUT_SH - 1));
	localparam logic signed [ZW-1:0] A_MAX = ZW'((64'sd1 <<< (AW - 1)) - 64'sd1);
	localparam logic signed [ZW-1:0] A_MIN = -A_MAX - ZW'(64'sd1);

	logic signed [XW-1:0] x_s [0:N];
	logic signed [XW-1:0] y_s [0:N];
	logic signed [ZW-1:0] z_s [0:N];
	logic                 zero_s [0:N];
	logic                 vld_s  [0:N];

	// Pre-rotate by pi for a left half-plane vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (in_x == '0) && (in_y == '0);
			if (in_x < 0) begin
				x_s[0] <= -in_x;
				y_s[0] <= -in_y;
				z_s[0] <= (in_y >= 0) ? PI_Z : -PI_Z;
			end else begin
				x_s[0] <= in_x;
				y_s[0] <= in_y;
				z_s[0] <= '0;
			end
		end
	end

	// Vectoring steps, one per stage
	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic signed [ZW-1:0] STEP = qte_pkg::atan_step(k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k+1] <= zero_s[k];
				if (y_s[k] >= 0) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + STEP;
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - STEP;
				end
			end
		end
	end

	// Round half up to the output format and saturate
	logic signed [ZW-1:0] z_fin;
	logic signed [ZW-1:0] z_rnd;

	always_comb begin
		z_fin = zero_s[N] ? '0 : z_s[N];
		z_rnd = (z_fin + RND) >>> qte_pkg::OUT_SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_rnd > A_MAX) begin
				out_angle <= A_MAX[AW-1:0];
			end else if (z_rnd < A_MIN) begin
				out_angle <= A_MIN[AW-1:0];
			end else begin
				out_angle <= z_rnd[AW-1:0];
			end
		end
	end

endmodule

FILE: src/qte_isqrt.sv
module qte_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [qte_pkg::VW-1:0]        in_v,
	input  logic signed [qte_pkg::SW-1:0] in_tag,
	output logic                          out_valid,
	output logic [qte_pkg::SW-1:0]        out_root,
	output logic signed [qte_pkg::SW-1:0] out_tag
);

	localparam int N  = qte_pkg::ISQRT_STAGES;
	localparam int VW = qte_pkg::VW;
	localparam int SW = qte_pkg::SW;

	logic [VW-1:0]        rem_s [0:N];
	logic [VW-1:0]        res_s [0:N];
	logic signed [SW-1:0] tag_s [0:N];
	logic                 vld_s [0:N];

	always_comb begin
		rem_s[0] = in_v;
		res_s[0] = '0;
		tag_s[0] = in_tag;
		vld_s[0] = in_valid;
	end

	// Settle one root bit per stage, largest first
	for (genvar j = 0; j < N; j++) begin : g_bit
		localparam logic [VW:0] BIT = (VW+1)'(1) << (2 * (N - 1 - j));
		logic [VW:0] trial;

		assign trial = {1'b0, res_s[j]} + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[j+1] <= tag_s[j];
				if ({1'b0, rem_s[j]} >= trial) begin
					rem_s[j+1] <= rem_s[j] - trial[VW-1:0];
					res_s[j+1] <= (res_s[j] >> 1) + BIT[VW-1:0];
				end else begin
					rem_s[j+1] <= rem_s[j];
					res_s[j+1] <= res_s[j] >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_root  = res_s[N][SW-1:0];
	assign out_tag   = tag_s[N];

endmodule

FILE: src/qte_front.sv
module qte_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [qte_pkg::QW-1:0] quat_w,
	input  logic signed [qte_pkg::QW-1:0] quat_x,
	input  logic signed [qte_pkg::QW-1:0] quat_y,
	input  logic signed [qte_pkg::QW-1:0] quat_z,
	input  logic [qte_pkg::TW-1:0]        lock_threshold,
	input  qte_pkg::q_stat_t              q_stat,
	output logic                          q_push,
	output qte_pkg::qitem_t               q_item
);

	localparam int QW = qte_pkg::QW;
	localparam int PW = qte_pkg::PW;
	localparam int EW = qte_pkg::EW;
	localparam int XW = qte_pkg::XW;
	localparam int SW = qte_pkg::SW;
	localparam int VW = qte_pkg::VW;
	localparam int AW = qte_pkg::ANGLE_WIDTH;
	localparam int D  = qte_pkg::FRONT_DLY;
	localparam logic signed [EW-1:0] E_ONE = EW'(qte_pkg::ONE_VAL);
	localparam logic [VW-1:0] V_TOP = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [AW:0] HALF = (AW+1)'(qte_pkg::HALF_OUT);

	function automatic logic signed [EW-1:0] ext(input logic signed [PW-1:0] p);
		return $signed({{(EW-PW){p[PW-1]}}, p});
	endfunction

	logic front_en;
	logic cls_valid_q;

	// Hold the whole front while its last request waits on a full queue
	assign front_en = !(cls_valid_q && q_stat.full);
	assign in_stall = !front_en;
	assign q_push   = cls_valid_q && !q_stat.full;

	// Stage 1: capture request
	logic                 vld_s1;
	logic signed [QW-1:0] a_s1, b_s1, c_s1, d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (front_en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			a_s1 <= quat_w;
			b_s1 <= quat_x;
			c_s1 <= quat_y;
			d_s1 <= quat_z;
		end
	end

	// Stage 2: component products
	logic                 vld_s2;
	logic signed [PW-1:0] aa_s2, bb_s2, cc_s2, dd_s2, ac_s2, bd_s2, bc_s2, ad_s2, cd_s2, ab_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (front_en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			aa_s2 <= a_s1 * a_s1;
			bb_s2 <= b_s1 * b_s1;
			cc_s2 <= c_s1 * c_s1;
			dd_s2 <= d_s1 * d_s1;
			ac_s2 <= a_s1 * c_s1;
			bd_s2 <= b_s1 * d_s1;
			bc_s2 <= b_s1 * c_s1;
			ad_s2 <= a_s1 * d_s1;
			cd_s2 <= c_s1 * d_s1;
			ab_s2 <= a_s1 * b_s1;
		end
	end

	// Stage 3: direction cosine elements
	logic                 vld_s3;
	qte_pkg::elem_t       e_s3;
	logic signed [EW-1:0] e20_s3;
	logic signed [EW-1:0] sum02, sum10, sum12, sum20, sum21;

	always_comb begin
		sum02 = ext(ac_s2) + ext(bd_s2);
		sum10 = ext(bc_s2) + ext(ad_s2);
		sum12 = ext(cd_s2) - ext(ab_s2);
		sum20 = ext(bd_s2) - ext(ac_s2);
		sum21 = ext(ab_s2) + ext(cd_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (front_en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			e_s3.e00 <= ext(aa_s2) + ext(bb_s2) - ext(cc_s2) - ext(dd_s2);
			e_s3.e02 <= sum02 + sum02;
			e_s3.e10 <= sum10 + sum10;
			e_s3.e12 <= sum12 + sum12;
			e_s3.e21 <= sum21 + sum21;
			e_s3.e22 <= ext(aa_s2) - ext(bb_s2) - ext(cc_s2) + ext(dd_s2);
			e20_s3   <= sum20 + sum20;
		end
	end

	// Stage 4: clamp the arcsine operand to plus or minus one
	logic                 vld_s4;
	logic signed [SW-1:0] s_s4;
	logic signed [EW-1:0] neg20;

	assign neg20 = -e20_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (front_en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			if (neg20 > E_ONE) begin
				s_s4 <= E_ONE[SW-1:0];
			end else if (neg20 < -E_ONE) begin
				s_s4 <= SW'(-E_ONE);
			end else begin
				s_s4 <= neg20[SW-1:0];
			end
		end
	end

	// Stage 5: square
	logic                     vld_s5;
	logic signed [SW-1:0]     s_s5;
	logic [VW-1:0]            sq_s5;
	logic signed [2*SW-1:0]   sq_full;

	assign sq_full = s_s4 * s_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (front_en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			s_s5  <= s_s4;
			sq_s5 <= sq_full[VW-1:0];
		end
	end

	// Stage 6: radicand of the cosine
	logic                 vld_s6;
	logic signed [SW-1:0] s_s6;
	logic [VW-1:0]        v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (front_en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			s_s6 <= s_s5;
			v_s6 <= V_TOP - sq_s5;
		end
	end

	// Cosine by integer square root
	logic                 rt_valid;
	logic [SW-1:0]        rt_root;
	logic signed [SW-1:0] rt_s;

	qte_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (front_en),
		.in_valid  (vld_s6),
		.in_v      (v_s6),
		.in_tag    (s_s6),
		.out_valid (rt_valid),
		.out_root  (rt_root),
		.out_tag   (rt_s)
	);

	// Pitch as atan2(sine, cosine)
	logic                 p_valid;
	logic signed [AW-1:0] p_angle;

	qte_cordic u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (front_en),
		.in_valid  (rt_valid),
		.in_y      ($signed({{(XW-SW){rt_s[SW-1]}}, rt_s})),
		.in_x      ($signed({{(XW-SW){1'b0}}, rt_root})),
		.out_valid (p_valid),
		.out_angle (p_angle)
	);

	// Carry the elements alongside the pitch path
	qte_pkg::elem_t e_dly_q [0:D-1];

	always_ff @(posedge clk) begin
		if (front_en) begin
			e_dly_q[0] <= e_s3;
			for (int k = 1; k < D; k++) begin
				e_dly_q[k] <= e_dly_q[k-1];
			end
		end
	end

	// Classify gimbal lock and select the yaw operands
	qte_pkg::elem_t       e_al;
	logic signed [AW:0]   dp, dm, dp_abs, dm_abs, thr;

	always_comb begin
		e_al   = e_dly_q[D-1];
		dp     = $signed({p_angle[AW-1], p_angle}) - HALF;
		dm     = $signed({p_angle[AW-1], p_angle}) + HALF;
		dp_abs = (dp < 0) ? -dp : dp;
		dm_abs = (dm < 0) ? -dm : dm;
		thr    = $signed({{(AW+1-qte_pkg::TW){1'b0}}, lock_threshold});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_valid_q <= 1'b0;
		end else if (front_en) begin
			cls_valid_q <= p_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			q_item.pitch  <= p_angle;
			q_item.roll_y <= e_al.e21;
			q_item.roll_x <= e_al.e22;
			if (dp_abs < thr) begin
				q_item.status <= qte_pkg::LOCK_POS;
				q_item.yaw_y  <= e_al.e12;
				q_item.yaw_x  <= e_al.e02;
			end else if (dm_abs < thr) begin
				q_item.status <= qte_pkg::LOCK_NEG;
				q_item.yaw_y  <= -e_al.e12;
				q_item.yaw_x  <= -e_al.e02;
			end else begin
				q_item.status <= qte_pkg::LOCK_NONE;
				q_item.yaw_y  <= e_al.e10;
				q_item.yaw_x  <= e_al.e00;
			end
		end
	end

endmodule

FILE: src/qte_queue.sv
module qte_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qte_pkg::qitem_t  push_item,
	input  logic             pop,
	output qte_pkg::qitem_t  pop_item,
	output qte_pkg::q_stat_t stat
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	qte_pkg::qitem_t mem_q [0:DEPTH-1];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;

	assign stat.full  = (cnt_q == (AW+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_item   = mem_q[rd_q];

	// Write entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/qte_back.sv
module qte_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  qte_pkg::q_stat_t                       q_stat,
	input  qte_pkg::qitem_t                        q_item,
	output logic                                   q_pop,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [qte_pkg::ANGLE_WIDTH-1:0] roll_angle,
	output logic signed [qte_pkg::ANGLE_WIDTH-1:0] pitch_angle,
	output logic signed [qte_pkg::ANGLE_WIDTH-1:0] yaw_angle,
	output logic [1:0]                             lock_status
);

	localparam int AW  = qte_pkg::ANGLE_WIDTH;
	localparam int XW  = qte_pkg::XW;
	localparam int EW  = qte_pkg::EW;
	localparam int LAT = qte_pkg::CORDIC_LAT;

	logic back_en;

	// Advance unless a result waits at a stalled output
	assign back_en = !(out_valid && out_stall);
	assign q_pop   = back_en && !q_stat.empty;

	logic                 r_valid, y_valid;
	logic signed [AW-1:0] r_angle, y_angle;

	qte_cordic u_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (back_en),
		.in_valid  (!q_stat.empty),
		.in_y      ($signed({{(XW-EW){q_item.roll_y[EW-1]}}, q_item.roll_y})),
		.in_x      ($signed({{(XW-EW){q_item.roll_x[EW-1]}}, q_item.roll_x})),
		.out_valid (r_valid),
		.out_angle (r_angle)
	);

	qte_cordic u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (back_en),
		.in_valid  (!q_stat.empty),
		.in_y      ($signed({{(XW-EW){q_item.yaw_y[EW-1]}}, q_item.yaw_y})),
		.in_x      ($signed({{(XW-EW){q_item.yaw_x[EW-1]}}, q_item.yaw_x})),
		.out_valid (y_valid),
		.out_angle (y_angle)
	);

	// Carry pitch and status alongside the arctangents
	logic signed [AW-1:0] pitch_dly_q  [0:LAT-1];
	qte_pkg::lock_t       status_dly_q [0:LAT-1];

	always_ff @(posedge clk) begin
		if (back_en) begin
			pitch_dly_q[0]  <= q_item.pitch;
			status_dly_q[0] <= q_item.status;
			for (int k = 1; k < LAT; k++) begin
				pitch_dly_q[k]  <= pitch_dly_q[k-1];
				status_dly_q[k] <= status_dly_q[k-1];
			end
		end
	end

	// Output register; drop roll when locked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (back_en) begin
			out_valid <= r_valid && y_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (back_en) begin
			pitch_angle <= pitch_dly_q[LAT-1];
			yaw_angle   <= y_angle;
			lock_status <= status_dly_q[LAT-1];
			roll_angle  <= (status_dly_q[LAT-1] == qte_pkg::LOCK_NONE) ? r_angle : '0;
		end
	end

endmodule

FILE: src/quaternion_to_euler_321.sv
// Throughput: one request per cycle; the input stalls only while the four-entry
// queue between the pitch/classify front and the roll/yaw back is full.
// Latency is set by the 29-stage square root and the 18-stage CORDIC pipes.
// Reset (arst_n low, asynchronous): pipelines and queue empty, lock threshold 8.
module quaternion_to_euler_321 (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [15:0]                     quat_w,
	input  logic signed [15:0]                     quat_x,
	input  logic signed [15:0]                     quat_y,
	input  logic signed [15:0]                     quat_z,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [qte_pkg::ANGLE_WIDTH-1:0] roll_angle,
	output logic signed [qte_pkg::ANGLE_WIDTH-1:0] pitch_angle,
	output logic signed [qte_pkg::ANGLE_WIDTH-1:0] yaw_angle,
	output logic [1:0]                             lock_status,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [7:0]                             cfg_data
);

	logic [qte_pkg::TW-1:0] lock_threshold_q;

	// Lock threshold register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_threshold_q <= 8'd8;
		end else if (cfg_valid && cfg_ready) begin
			lock_threshold_q <= cfg_data;
		end
	end

	qte_pkg::q_stat_t q_stat;
	qte_pkg::qitem_t  push_item, pop_item;
	logic             q_push, q_pop;

	qte_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.quat_w         (quat_w),
		.quat_x         (quat_x),
		.quat_y         (quat_y),
		.quat_z         (quat_z),
		.lock_threshold (lock_threshold_q),
		.q_stat         (q_stat),
		.q_push         (q_push),
		.q_item         (push_item)
	);

	qte_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.stat      (q_stat)
	);

	qte_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle),
		.lock_status (lock_status)
	);

endmodule

FILE: src/qte_checker.sv
module qte_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_stall,
	input logic signed [15:0]                     quat_w,
	input logic signed [15:0]                     quat_x,
	input logic signed [15:0]                     quat_y,
	input logic signed [15:0]                     quat_z,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic signed [qte_pkg::ANGLE_WIDTH-1:0] roll_angle,
	input logic signed [qte_pkg::ANGLE_WIDTH-1:0] pitch_angle,
	input logic signed [qte_pkg::ANGLE_WIDTH-1:0] yaw_angle,
	input logic [1:0]                             lock_status,
	input logic                                   cfg_valid,
	input logic                                   cfg_ready,
	input logic [7:0]                             cfg_data
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(roll_angle) && $stable(pitch_angle)
			&& $stable(yaw_angle) && $stable(lock_status))
		else $error("stalled result changed");

	// Locked results carry zero roll
	a_lock_roll: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (lock_status != qte_pkg::LOCK_NONE) |-> roll_angle == '0)
		else $error("roll not zero under gimbal lock");

	// Positive lock comes with positive pitch
	a_lock_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (lock_status == qte_pkg::LOCK_POS) |-> pitch_angle > 0)
		else $error("positive lock with non-positive pitch");

endmodule

bind quaternion_to_euler_321 qte_checker u_qte_checker (.*);
